@@ sv/prb_pkg.sv @@
// Shared types, constants and helpers for the probe packet header generator.
// No dependencies; every other file refers to this package by scoped names.
package prb_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ADDRESS     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_PORT_NUMBER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOP_LIMIT          = 2'd2;

	localparam logic [31:0] SOURCE_ADDRESS_RESET     = 32'h0A0B_64E8;
	localparam logic [15:0] SOURCE_PORT_NUMBER_RESET = 16'd0;
	localparam logic [7:0]  HOP_LIMIT_RESET          = 8'd64;

	// Header constants
	localparam logic [7:0]  VER_IHL     = 8'h45;
	localparam logic [7:0]  TCP_OFFSET  = 8'h50;
	localparam logic [7:0]  PROTO_TCP   = 8'd6;
	localparam logic [7:0]  PROTO_UDP   = 8'd17;
	localparam logic [15:0] TOT_LEN_TCP = 16'd40;
	localparam logic [15:0] TOT_LEN_UDP = 16'd28;
	localparam logic [15:0] L4_LEN_TCP  = 16'd20;
	localparam logic [15:0] L4_LEN_UDP  = 16'd8;
	localparam logic [15:0] TCP_WINDOW  = 16'd1024;

	// Scan kinds and TCP flag bits
	localparam logic [2:0] KIND_SYN  = 3'd0;
	localparam logic [2:0] KIND_ACK  = 3'd1;
	localparam logic [2:0] KIND_FIN  = 3'd2;
	localparam logic [2:0] KIND_XMAS = 3'd3;

	localparam logic [7:0] FLAG_FIN = 8'h01;
	localparam logic [7:0] FLAG_SYN = 8'h02;
	localparam logic [7:0] FLAG_PSH = 8'h08;
	localparam logic [7:0] FLAG_ACK = 8'h10;
	localparam logic [7:0] FLAG_URG = 8'h20;

	// Raw checksum accumulator: at most twelve 16-bit terms
	localparam int SUM_W = 20;

	// Word position within a packet
	typedef enum logic [3:0] {
		W_VER, W_IDENT, W_TTL, W_SRC, W_DST,
		W_PORTS, W_SEQ_ULEN, W_ACK, W_OFFS, W_CSUM
	} word_t;

	typedef struct packed {
		logic [31:0] dest_address;
		logic [15:0] dest_port_number;
		logic        use_udp;
		logic [2:0]  scan_kind;
		logic [15:0] ident;
		logic [31:0] sequence_value;
	} probe_t;

	typedef struct packed {
		logic [31:0] header_word;
		logic        last_word;
	} pkt_t;

	typedef struct packed {
		logic [31:0] source_address;
		logic [15:0] source_port_number;
		logic [7:0]  hop_limit;
	} cfg_t;

	// Classified request, ready to be serialized
	typedef struct packed {
		logic [31:0] dest_address;
		logic [15:0] dest_port_number;
		logic        use_udp;
		logic [7:0]  flags;
		logic [15:0] ident;
		logic [31:0] sequence_value;
		logic [15:0] ip_csum;
		logic [15:0] l4_csum;
	} desc_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [7:0] tcp_flags(input logic [2:0] kind);
		logic [7:0] f;
		unique case (kind)
			KIND_SYN:  f = FLAG_SYN;
			KIND_ACK:  f = FLAG_ACK;
			KIND_FIN:  f = FLAG_FIN;
			KIND_XMAS: f = FLAG_FIN | FLAG_PSH | FLAG_URG;
			default:   f = 8'h00;
		endcase
		return f;
	endfunction

	function automatic logic [SUM_W-1:0] sum_ext(input logic [15:0] v);
		return {{(SUM_W-16){1'b0}}, v};
	endfunction

	// Two end-around folds are enough for a sum below 2^20
	function automatic logic [15:0] fold_csum(input logic [SUM_W-1:0] s);
		logic [16:0] f1;
		logic [16:0] f2;
		f1 = {1'b0, s[15:0]} + {{(17-(SUM_W-16)){1'b0}}, s[SUM_W-1:16]};
		f2 = {1'b0, f1[15:0]} + {16'd0, f1[16]};
		return ~f2[15:0];
	endfunction

endpackage

@@ sv/prb_front.sv @@
// Front end: takes probe requests, sums header fields and folds checksums.
// Depends on prb_pkg; feeds a classified descriptor into prb_queue.
module prb_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            probe_valid,
	output logic            probe_stall,
	input  prb_pkg::probe_t probe,
	input  prb_pkg::cfg_t   cfg,
	input  prb_pkg::q_stat_t q_stat,
	output logic            push,
	output prb_pkg::desc_t  push_data
);

	logic                     valid_s1;
	prb_pkg::probe_t          req_s1;
	logic                     valid_s2;
	prb_pkg::desc_t           desc_s2;
	logic [prb_pkg::SUM_W-1:0] ip_sum_s2;
	logic [prb_pkg::SUM_W-1:0] l4_sum_s2;

	logic                     adv_s1;
	logic                     adv_s2;
	logic                     ld_s1;
	logic [7:0]               proto;
	logic [15:0]              tot_len;
	logic [15:0]              l4_len;
	logic [7:0]               flags;
	logic [prb_pkg::SUM_W-1:0] ip_sum;
	logic [prb_pkg::SUM_W-1:0] l4_sum;
	logic [15:0]              l4_ck;

	// Pipeline flow: s2 drains into the queue, s1 into s2
	assign adv_s2      = valid_s2 && !q_stat.full;
	assign adv_s1      = !valid_s2 || adv_s2;
	// s1 takes a new request when empty or moving on
	assign ld_s1       = !valid_s1 || adv_s1;
	assign probe_stall = !ld_s1;
	assign push        = adv_s2;

	// Classify the request held in s1
	always_comb begin
		proto   = req_s1.use_udp ? prb_pkg::PROTO_UDP : prb_pkg::PROTO_TCP;
		tot_len = req_s1.use_udp ? prb_pkg::TOT_LEN_UDP : prb_pkg::TOT_LEN_TCP;
		l4_len  = req_s1.use_udp ? prb_pkg::L4_LEN_UDP : prb_pkg::L4_LEN_TCP;
		flags   = req_s1.use_udp ? 8'h00 : prb_pkg::tcp_flags(req_s1.scan_kind);
	end

	// Raw ones-complement sums; checksum fields count as zero
	always_comb begin
		ip_sum = prb_pkg::sum_ext({prb_pkg::VER_IHL, 8'h00})
			+ prb_pkg::sum_ext(tot_len)
			+ prb_pkg::sum_ext(req_s1.ident)
			+ prb_pkg::sum_ext({cfg.hop_limit, proto})
			+ prb_pkg::sum_ext(cfg.source_address[31:16])
			+ prb_pkg::sum_ext(cfg.source_address[15:0])
			+ prb_pkg::sum_ext(req_s1.dest_address[31:16])
			+ prb_pkg::sum_ext(req_s1.dest_address[15:0]);
		l4_sum = prb_pkg::sum_ext(cfg.source_address[31:16])
			+ prb_pkg::sum_ext(cfg.source_address[15:0])
			+ prb_pkg::sum_ext(req_s1.dest_address[31:16])
			+ prb_pkg::sum_ext(req_s1.dest_address[15:0])
			+ prb_pkg::sum_ext({8'h00, proto})
			+ prb_pkg::sum_ext(l4_len)
			+ prb_pkg::sum_ext(cfg.source_port_number)
			+ prb_pkg::sum_ext(req_s1.dest_port_number);
		if (req_s1.use_udp) begin
			// UDP length word
			l4_sum = l4_sum + prb_pkg::sum_ext(prb_pkg::L4_LEN_UDP);
		end else begin
			l4_sum = l4_sum
				+ prb_pkg::sum_ext(req_s1.sequence_value[31:16])
				+ prb_pkg::sum_ext(req_s1.sequence_value[15:0])
				+ prb_pkg::sum_ext({prb_pkg::TCP_OFFSET, flags})
				+ prb_pkg::sum_ext(prb_pkg::TCP_WINDOW);
		end
	end

	// Stage registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ld_s1) begin
				valid_s1 <= probe_valid;
			end
			if (adv_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1 && probe_valid) begin
			req_s1 <= probe;
		end
		if (adv_s1 && valid_s1) begin
			desc_s2.dest_address     <= req_s1.dest_address;
			desc_s2.dest_port_number <= req_s1.dest_port_number;
			desc_s2.use_udp          <= req_s1.use_udp;
			desc_s2.flags            <= flags;
			desc_s2.ident            <= req_s1.ident;
			desc_s2.sequence_value   <= req_s1.sequence_value;
			desc_s2.ip_csum          <= 16'h0000;
			desc_s2.l4_csum          <= 16'h0000;
			ip_sum_s2                <= ip_sum;
			l4_sum_s2                <= l4_sum;
		end
	end

	// Fold and complement; a zero UDP checksum goes out as all ones
	always_comb begin
		l4_ck = prb_pkg::fold_csum(l4_sum_s2);
		if (desc_s2.use_udp && (l4_ck == 16'h0000)) begin
			l4_ck = 16'hFFFF;
		end
		push_data         = desc_s2;
		push_data.ip_csum = prb_pkg::fold_csum(ip_sum_s2);
		push_data.l4_csum = l4_ck;
	end

endmodule

@@ sv/prb_queue.sv @@
// Short descriptor queue between front end and word sequencer.
// Depends on prb_pkg for the descriptor and status types.
module prb_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  prb_pkg::desc_t   wdata,
	input  logic             pop,
	output prb_pkg::desc_t   head,
	output prb_pkg::q_stat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	prb_pkg::desc_t   entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head       = entries_q[rd_ptr_q];
	assign stat.full  = (count_q == FULL_CNT);
	assign stat.empty = (count_q == '0);

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

@@ sv/prb_back.sv @@
// Back end: serializes the queue head into 32-bit packet words, one a cycle unless stalled.
// Depends on prb_pkg; owns the output register of the packet channel.
module prb_back (
	input  logic             clk,
	input  logic             arst_n,
	input  prb_pkg::cfg_t    cfg,
	input  prb_pkg::desc_t   head,
	input  prb_pkg::q_stat_t q_stat,
	output logic             pop,
	output logic             pkt_valid,
	input  logic             pkt_stall,
	output prb_pkg::pkt_t    pkt
);

	prb_pkg::word_t word_q;
	logic           valid_q;
	prb_pkg::pkt_t  pkt_q;

	logic           load;
	logic           is_last;
	logic [31:0]    word_data;
	logic [7:0]     proto;
	logic [15:0]    tot_len;

	assign load      = !q_stat.empty && (!valid_q || !pkt_stall);
	assign is_last   = head.use_udp ? (word_q == prb_pkg::W_SEQ_ULEN)
	                                : (word_q == prb_pkg::W_CSUM);
	assign pop       = load && is_last;
	assign pkt_valid = valid_q;
	assign pkt       = pkt_q;

	assign proto   = head.use_udp ? prb_pkg::PROTO_UDP : prb_pkg::PROTO_TCP;
	assign tot_len = head.use_udp ? prb_pkg::TOT_LEN_UDP : prb_pkg::TOT_LEN_TCP;

	// Word select by position
	always_comb begin
		unique case (word_q)
			prb_pkg::W_VER:   word_data = {prb_pkg::VER_IHL, 8'h00, tot_len};
			prb_pkg::W_IDENT: word_data = {head.ident, 16'h0000};
			prb_pkg::W_TTL:   word_data = {cfg.hop_limit, proto, head.ip_csum};
			prb_pkg::W_SRC:   word_data = cfg.source_address;
			prb_pkg::W_DST:   word_data = head.dest_address;
			prb_pkg::W_PORTS: word_data = {cfg.source_port_number, head.dest_port_number};
			prb_pkg::W_SEQ_ULEN: begin
				word_data = head.use_udp ? {prb_pkg::L4_LEN_UDP, head.l4_csum}
				                         : head.sequence_value;
			end
			prb_pkg::W_ACK:   word_data = 32'h0000_0000;
			prb_pkg::W_OFFS:  word_data = {prb_pkg::TCP_OFFSET, head.flags, prb_pkg::TCP_WINDOW};
			prb_pkg::W_CSUM:  word_data = {head.l4_csum, 16'h0000};
			default:          word_data = 32'h0000_0000;
		endcase
	end

	// Word counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q  <= prb_pkg::W_VER;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				word_q  <= is_last ? prb_pkg::W_VER : prb_pkg::word_t'(word_q + 4'd1);
				valid_q <= 1'b1;
			end else if (!pkt_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load) begin
			pkt_q.header_word <= word_data;
			pkt_q.last_word   <= is_last;
		end
	end

endmodule

@@ sv/probe_packet_header_generator_core.sv @@
// Probe packet header generator: builds IPv4 TCP/UDP probe packets as words.
// Usage notes:
//   Requests arrive on probe/probe_valid/probe_stall; a transfer happens at a
//   clock edge with probe_valid high and probe_stall low. Packet words leave
//   on pkt/pkt_valid/pkt_stall, one 32-bit network-order word per transfer,
//   with last_word set on the final word of each packet.
//   A TCP packet is 10 words, a UDP packet 7 words. The word sequencer emits
//   one word per cycle while pkt_stall is low, so the rate of a stream of
//   requests is set by the word count of each packet.
//   When the queue is empty, the first word of a request passes the input
//   stage, checksum sum stage, fold into the queue and output register in order.
//   Up to QUEUE_DEPTH checksummed requests wait between front and back, so
//   the front keeps accepting while a packet is being sent.
//   When the receiver holds pkt_stall, the current word stays put and the
//   queue fills; probe_stall rises once the queue and both front stages hold.
//   Reset clears all handshake state and loads the configuration registers
//   with their defaults. Configuration writes (cfg_we, cfg_index, cfg_wdata)
//   take effect on the next edge and must only be made while the block is idle.
module probe_packet_header_generator_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            probe_valid,
	output logic                            probe_stall,
	input  prb_pkg::probe_t                 probe,
	output logic                            pkt_valid,
	input  logic                            pkt_stall,
	output prb_pkg::pkt_t                   pkt,
	input  logic                            cfg_we,
	input  logic [prb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [prb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	prb_pkg::cfg_t    cfg_q;
	prb_pkg::q_stat_t q_stat;
	prb_pkg::desc_t   q_wdata;
	prb_pkg::desc_t   q_head;
	logic             q_push;
	logic             q_pop;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_address     <= prb_pkg::SOURCE_ADDRESS_RESET;
			cfg_q.source_port_number <= prb_pkg::SOURCE_PORT_NUMBER_RESET;
			cfg_q.hop_limit          <= prb_pkg::HOP_LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				prb_pkg::REG_SOURCE_ADDRESS:     cfg_q.source_address <= cfg_wdata;
				prb_pkg::REG_SOURCE_PORT_NUMBER: cfg_q.source_port_number <= cfg_wdata[15:0];
				prb_pkg::REG_HOP_LIMIT:          cfg_q.hop_limit <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	prb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.probe_valid (probe_valid),
		.probe_stall (probe_stall),
		.probe       (probe),
		.cfg         (cfg_q),
		.q_stat      (q_stat),
		.push        (q_push),
		.push_data   (q_wdata)
	);

	prb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.head   (q_head),
		.stat   (q_stat)
	);

	prb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (q_head),
		.q_stat    (q_stat),
		.pop       (q_pop),
		.pkt_valid (pkt_valid),
		.pkt_stall (pkt_stall),
		.pkt       (pkt)
	);

	// Queue never overflows or underflows
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("descriptor pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("descriptor popped from an empty queue");

	// A final word is either the UDP length/checksum or the TCP checksum/urgent word
	a_last_word_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(pkt_valid && pkt.last_word) |->
			((pkt.header_word[31:16] == prb_pkg::L4_LEN_UDP) ||
			 (pkt.header_word[15:0] == 16'h0000)))
		else $error("last word has neither UDP nor TCP trailer layout");

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for probe_packet_header_generator_core.
// Predicts every packet word from the request and the register settings.
// Depends on prb_pkg and the core RTL only.
module tb_top;

	localparam int TCP_WORDS   = 10;
	localparam int UDP_WORDS   = 7;
	localparam int LONG_HOLD   = 300;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 10;

	// Register index with no register behind it
	localparam logic [prb_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// Scan kinds that the package leaves unnamed
	localparam logic [2:0] KIND_NONE   = 3'd4;
	localparam logic [2:0] KIND_RSVD5  = 3'd5;
	localparam logic [2:0] KIND_RSVD6  = 3'd6;
	localparam logic [2:0] KIND_RSVD7  = 3'd7;

	// One request plus optional hand-typed words that override the prediction
	typedef struct packed {
		prb_pkg::probe_t req;
		logic            pin_first;
		logic [31:0]     first;
		logic            pin_key;
		logic [31:0]     key;
	} row_t;

	logic                           clk         = 1'b0;
	logic                           arst_n      = 1'b0;
	logic                           probe_valid = 1'b0;
	logic                           probe_stall;
	prb_pkg::probe_t                probe       = '0;
	logic                           pkt_valid;
	logic                           pkt_stall   = 1'b0;
	prb_pkg::pkt_t                  pkt;
	logic                           cfg_we      = 1'b0;
	logic [prb_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [prb_pkg::CFG_DATA_W-1:0] cfg_wdata   = '0;

	prb_pkg::cfg_t  cfg_shadow;
	prb_pkg::pkt_t  packet_words [$];
	row_t           dir_rows [$];
	int             tx_gap_pct         = 0;
	int             rx_gap_pct         = 0;
	bit             hold_output        = 1'b0;
	int             fail_cnt           = 0;
	int             no_transfer_cycles = 0;

	probe_packet_header_generator_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.probe_valid (probe_valid),
		.probe_stall (probe_stall),
		.probe       (probe),
		.pkt_valid   (pkt_valid),
		.pkt_stall   (pkt_stall),
		.pkt         (pkt),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Ones-complement fold: add carries back in until none remain
	function automatic logic [15:0] ones_fold(input logic [31:0] s);
		logic [31:0] t;
		t = s;
		while (t[31:16] != 16'd0)
			t = {16'd0, t[15:0]} + {16'd0, t[31:16]};
		return ~t[15:0];
	endfunction

	function automatic logic [7:0] flags_of(input logic [2:0] kind);
		logic [7:0] f;
		case (kind)
			prb_pkg::KIND_SYN:  f = prb_pkg::FLAG_SYN;
			prb_pkg::KIND_ACK:  f = prb_pkg::FLAG_ACK;
			prb_pkg::KIND_FIN:  f = prb_pkg::FLAG_FIN;
			prb_pkg::KIND_XMAS: f = prb_pkg::FLAG_FIN | prb_pkg::FLAG_PSH | prb_pkg::FLAG_URG;
			default:            f = 8'h00;
		endcase
		return f;
	endfunction

	// Build the packet words of one request and queue them
	function automatic void build_packet(input row_t t);
		logic [31:0] w [0:9];
		logic [31:0] sum;
		logic [15:0] ck;
		logic [7:0]  proto;
		logic [15:0] l4len;
		int          n;
		int          i;
		proto = t.req.use_udp ? prb_pkg::PROTO_UDP : prb_pkg::PROTO_TCP;
		l4len = t.req.use_udp ? prb_pkg::L4_LEN_UDP : prb_pkg::L4_LEN_TCP;
		n     = t.req.use_udp ? UDP_WORDS : TCP_WORDS;
		w[0] = {prb_pkg::VER_IHL, 8'h00,
			t.req.use_udp ? prb_pkg::TOT_LEN_UDP : prb_pkg::TOT_LEN_TCP};
		w[1] = {t.req.ident, 16'h0000};
		w[2] = {cfg_shadow.hop_limit, proto, 16'h0000};
		w[3] = cfg_shadow.source_address;
		w[4] = t.req.dest_address;
		sum = 32'd0;
		for (i = 0; i < 5; i++)
			sum = sum + w[i][31:16] + w[i][15:0];
		w[2][15:0] = ones_fold(sum);

		// Transport header, summed over the pseudo-header first
		w[5] = {cfg_shadow.source_port_number, t.req.dest_port_number};
		sum = w[3][31:16] + w[3][15:0] + w[4][31:16] + w[4][15:0] + proto + l4len;
		if (t.req.use_udp) begin
			w[6] = {prb_pkg::L4_LEN_UDP, 16'h0000};
			for (i = 5; i < 7; i++)
				sum = sum + w[i][31:16] + w[i][15:0];
			ck = ones_fold(sum);
			// zero on the wire means no checksum
			if (ck == 16'h0000)
				ck = 16'hFFFF;
			w[6][15:0] = ck;
		end else begin
			w[6] = t.req.sequence_value;
			w[7] = 32'd0;
			w[8] = {prb_pkg::TCP_OFFSET, flags_of(t.req.scan_kind), prb_pkg::TCP_WINDOW};
			for (i = 5; i < 9; i++)
				sum = sum + w[i][31:16] + w[i][15:0];
			w[9] = {ones_fold(sum), 16'h0000};
		end

		if (t.pin_first)
			w[0] = t.first;
		if (t.pin_key)
			w[t.req.use_udp ? int'(prb_pkg::W_SEQ_ULEN) : int'(prb_pkg::W_OFFS)] = t.key;
		for (i = 0; i < n; i++)
			packet_words.push_back('{header_word: w[i], last_word: (i == n - 1)});
	endfunction

	function automatic void add_row(input logic [31:0] dst, input logic [15:0] dport,
			input logic udp, input logic [2:0] kind, input logic [15:0] ident,
			input logic [31:0] seq, input logic pf, input logic [31:0] first,
			input logic pk, input logic [31:0] key);
		row_t t;
		t.req.dest_address     = dst;
		t.req.dest_port_number = dport;
		t.req.use_udp          = udp;
		t.req.scan_kind        = kind;
		t.req.ident            = ident;
		t.req.sequence_value   = seq;
		t.pin_first            = pf;
		t.first                = first;
		t.pin_key              = pk;
		t.key                  = key;
		dir_rows.push_back(t);
	endfunction

	function automatic logic [31:0] biased_word();
		logic [31:0] v;
		case ($urandom_range(0, 7))
			0:       v = '0;
			1:       v = '1;
			default: v = $urandom();
		endcase
		return v;
	endfunction

	function automatic prb_pkg::probe_t random_probe();
		prb_pkg::probe_t r;
		logic [31:0]     v;
		r.dest_address = biased_word();
		v = biased_word();
		r.dest_port_number = v[15:0];
		v = biased_word();
		r.ident = v[15:0];
		r.sequence_value = biased_word();
		r.use_udp = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 9) < 8)
			r.scan_kind = 3'($urandom_range(prb_pkg::KIND_SYN, KIND_NONE));
		else
			r.scan_kind = 3'($urandom_range(KIND_RSVD5, KIND_RSVD7));
		return r;
	endfunction

	// Offer one request, maybe after a gap, and predict it on transfer
	task automatic offer_probe(input row_t t);
		int n;
		if ($urandom_range(1, 100) <= tx_gap_pct) begin
			probe_valid <= 1'b0;
			n = $urandom_range(1, 16);
			repeat (n) @(posedge clk);
		end
		probe <= t.req;
		probe_valid <= 1'b1;
		@(posedge clk);
		while (probe_stall)
			@(posedge clk);
		build_packet(t);
	endtask

	task automatic offer_random(input int count);
		row_t t;
		int   i;
		for (i = 0; i < count; i++) begin
			t = '0;
			t.req = random_probe();
			offer_probe(t);
		end
	endtask

	// Stop offering and wait for every predicted word
	task automatic drain();
		probe_valid <= 1'b0;
		while (packet_words.size() != 0)
			@(posedge clk);
	endtask

	// Write all registers back to back; upper data bits may carry junk
	task automatic load_config(input logic [31:0] addr, input logic [31:0] port,
			input logic [31:0] ttl, input bit poke_unused);
		cfg_we    <= 1'b1;
		cfg_index <= prb_pkg::REG_SOURCE_ADDRESS;
		cfg_wdata <= addr;
		@(posedge clk);
		cfg_index <= prb_pkg::REG_SOURCE_PORT_NUMBER;
		cfg_wdata <= port;
		@(posedge clk);
		cfg_index <= prb_pkg::REG_HOP_LIMIT;
		cfg_wdata <= ttl;
		@(posedge clk);
		if (poke_unused) begin
			cfg_index <= REG_UNUSED;
			cfg_wdata <= $urandom();
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cfg_shadow.source_address     = addr;
		cfg_shadow.source_port_number = port[15:0];
		cfg_shadow.hop_limit          = ttl[7:0];
	endtask

	// Receiver: random stall bursts, plus one long hold on request
	initial begin : rx_side
		int n;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_output) begin
				pkt_stall <= 1'b1;
				for (n = 0; n < LONG_HOLD; n++)
					@(posedge clk);
				pkt_stall <= 1'b0;
				hold_output = 1'b0;
			end else if ($urandom_range(1, 100) <= rx_gap_pct) begin
				pkt_stall <= 1'b1;
				n = $urandom_range(1, 16);
				repeat (n) @(posedge clk);
				pkt_stall <= 1'b0;
			end
		end
	end

	// Compare each output transfer with the oldest predicted word
	always @(posedge clk) begin : pkt_check
		prb_pkg::pkt_t want;
		if (arst_n && pkt_valid && !pkt_stall) begin
			if (packet_words.size() == 0) begin
				if (fail_cnt < 10)
					$display("unexpected word %h last %b", pkt.header_word, pkt.last_word);
				fail_cnt++;
			end else begin
				want = packet_words.pop_front();
				if (pkt.header_word !== want.header_word ||
						pkt.last_word !== want.last_word) begin
					if (fail_cnt < 10)
						$display("word mismatch: expected %h last %b, got %h last %b",
							want.header_word, want.last_word,
							pkt.header_word, pkt.last_word);
					fail_cnt++;
				end
			end
		end
	end

	// Watchdog on cycles with no transfer on any port
	always @(posedge clk) begin
		if ((probe_valid && !probe_stall) || (pkt_valid && !pkt_stall) || cfg_we)
			no_transfer_cycles <= 0;
		else
			no_transfer_cycles <= no_transfer_cycles + 1;
		if (no_transfer_cycles >= STALL_LIMIT) begin
			$display("[probe_packet_header_generator_core] ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		cfg_shadow = {prb_pkg::SOURCE_ADDRESS_RESET, prb_pkg::SOURCE_PORT_NUMBER_RESET,
			prb_pkg::HOP_LIMIT_RESET};

		// Directed rows, all under the reset register values
		// all zero right after reset
		add_row('0, '0, 1'b0, prb_pkg::KIND_SYN, '0, '0, 1'b1, 32'h4500_0028,
			1'b1, 32'h5002_0400);
		// all ones
		add_row('1, '1, 1'b0, prb_pkg::KIND_ACK, '1, '1, 1'b1, 32'h4500_0028,
			1'b1, 32'h5010_0400);
		add_row(32'h0102_0304, 16'd80, 1'b0, prb_pkg::KIND_FIN, 16'h1234, 32'h89AB_CDEF,
			1'b0, '0, 1'b1, 32'h5001_0400);
		add_row(32'hC0A8_0001, 16'd443, 1'b0, prb_pkg::KIND_XMAS, 16'hBEEF, 32'h0000_0001,
			1'b0, '0, 1'b1, 32'h5029_0400);
		add_row(32'h7F00_0001, 16'd22, 1'b0, KIND_NONE, 16'h0001, 32'h8000_0000,
			1'b0, '0, 1'b1, 32'h5000_0400);
		// reserved scan kinds carry no flags
		add_row(32'h0A00_0002, 16'd1, 1'b0, KIND_RSVD5, 16'h5555, 32'h5555_5555,
			1'b0, '0, 1'b1, 32'h5000_0400);
		add_row(32'h0A00_0003, 16'd2, 1'b0, KIND_RSVD6, 16'hAAAA, 32'hAAAA_AAAA,
			1'b0, '0, 1'b1, 32'h5000_0400);
		add_row(32'h0A00_0004, 16'd3, 1'b0, KIND_RSVD7, 16'h8000, 32'h7FFF_FFFF,
			1'b0, '0, 1'b1, 32'h5000_0400);
		// UDP extremes; scan kind must not matter
		add_row('0, '0, 1'b1, prb_pkg::KIND_SYN, '0, '0, 1'b1, 32'h4500_001C, 1'b0, '0);
		add_row('1, '1, 1'b1, prb_pkg::KIND_XMAS, '1, '1, 1'b1, 32'h4500_001C, 1'b0, '0);
		// UDP checksum that computes to zero goes out as all ones
		add_row('0, 16'h90EB, 1'b1, prb_pkg::KIND_SYN, '0, '0, 1'b0, '0,
			1'b1, 32'h0008_FFFF);
		add_row('1, 16'h90EB, 1'b1, prb_pkg::KIND_ACK, 16'h0F0F, '0, 1'b0, '0,
			1'b1, 32'h0008_FFFF);
		// IP sum of 0x1FFFF: the first fold carries out again
		add_row(32'h0000_0BDF, 16'd7, 1'b0, prb_pkg::KIND_SYN, '1, '0, 1'b0, '0, 1'b0, '0);
		add_row('0, '1, 1'b0, prb_pkg::KIND_SYN, '0, '1, 1'b0, '0, 1'b0, '0);
		add_row(32'h7FFF_FFFF, '0, 1'b1, prb_pkg::KIND_FIN, 16'h8000, 32'h1234_5678,
			1'b0, '0, 1'b0, '0);

		tx_gap_pct = 10;
		rx_gap_pct = 10;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[k])
			offer_probe(dir_rows[k]);
		offer_random(70);

		// All registers at zero
		drain();
		load_config('0, '0, '0, 1'b0);
		tx_gap_pct = 30;
		rx_gap_pct = 5;
		offer_random(70);

		// All registers at maximum; receiver holds off while requests pile up
		drain();
		load_config('1, 32'h0000_FFFF, 32'h0000_00FF, 1'b0);
		tx_gap_pct = 0;
		rx_gap_pct = 20;
		hold_output = 1'b1;
		offer_random(40);
		tx_gap_pct = 15;
		offer_random(30);

		// Random values with junk in the unused data bits; sender pauses midway
		drain();
		load_config($urandom(), $urandom(), $urandom(), 1'b1);
		tx_gap_pct = 0;
		rx_gap_pct = 25;
		offer_random(40);
		drain();
		tx_gap_pct = 20;
		offer_random(40);

		// Closing stretch with no idling on either side
		drain();
		load_config($urandom(), {16'h0000, 16'($urandom())}, {24'h0, 8'($urandom())}, 1'b0);
		tx_gap_pct = 0;
		rx_gap_pct = 0;
		offer_random(80);

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_cnt == 0 && packet_words.size() == 0)
			$display("[probe_packet_header_generator_core] OK");
		else
			$display("[probe_packet_header_generator_core] ERROR");
		$finish;
	end

endmodule
